>>> rtl/deq_pkg.sv
package deq_pkg;

    localparam int DEPTH   = 16;
    localparam int DATA_W  = 32;
    localparam int MODE_W  = 3;
    localparam int STAT_W  = 2;
    localparam int CNT_W   = $clog2(DEPTH + 1);

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_BACK  = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_BACK   = 3'd3,
        MODE_DUMP       = 3'd4
    } t_mode;

    typedef enum logic [STAT_W-1:0] {
        STAT_DONE  = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_FROM_PREV,
        CELL_FROM_NEXT,
        CELL_FROM_HEAD,
        CELL_LOAD
    } t_cell_cmd;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DUMP = 2'b10
    } t_state;

endpackage

>>> rtl/deq_if.sv
interface deq_in_if;
    import deq_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

interface deq_out_if;
    import deq_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] data;
    logic [STAT_W-1:0]        status;
    logic [CNT_W-1:0]         entries;
    logic                     last;

    modport source (output valid, output data, output status, output entries,
                    output last, input ready);
    modport sink   (input valid, input data, input status, input entries,
                    input last, output ready);
endinterface

>>> rtl/deq_cell.sv
module deq_cell
    import deq_pkg::*;
(
    input  logic                     i_clk,
    input  t_cell_cmd                i_cmd,
    input  logic signed [DATA_W-1:0] i_prev,
    input  logic signed [DATA_W-1:0] i_next,
    input  logic signed [DATA_W-1:0] i_head,
    input  logic signed [DATA_W-1:0] i_load,
    output logic signed [DATA_W-1:0] o_q
);

    logic signed [DATA_W-1:0] r_q;
    logic signed [DATA_W-1:0] n_q;

    always_comb begin
        case (i_cmd)
            CELL_FROM_PREV: n_q = i_prev;
            CELL_FROM_NEXT: n_q = i_next;
            CELL_FROM_HEAD: n_q = i_head;
            CELL_LOAD:      n_q = i_load;
            default:        n_q = r_q;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule

>>> rtl/double_ended_queue.sv
// Double-ended queue of signed 32-bit words held in a row of shifting cells.
// Cell 0 always holds the front word; the back word sits at cell entries-1.
// Input channel i_in carries mode and value; output channel o_out carries
// data, status, entries and last. Every input word yields at least one
// output word, marked by last on its final one.
// Push front, push back, pop front, pop back and unknown modes give one
// output word in the cycle after acceptance; a new input word is taken
// every cycle while the output side keeps up.
// Dump rotates the row one cell per cycle while the output side keeps up,
// emitting the front word each time, and leaves the contents in their
// original order. Accepting a dump only enters the dump state, from which
// each word is registered; an empty dump gives one word with empty status.
// No input is taken during a dump that still has words to emit.
// The output word is registered; while the receiver stalls it holds, the
// cell row holds, and i_in.ready drops.
// Reset (synchronous, active low) empties the queue and drops o_out.valid;
// cell contents are not cleared and are never shown before being written.
module double_ended_queue
    import deq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    deq_in_if.sink    i_in,
    deq_out_if.source o_out
);

    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_count, n_count;
    logic [CNT_W-1:0]         r_left, n_left;
    logic                     r_out_valid, n_out_valid;
    logic signed [DATA_W-1:0] r_out_data, n_out_data;
    t_status                  r_out_status, n_out_status;
    logic [CNT_W-1:0]         r_out_entries, n_out_entries;
    logic                     r_out_last, n_out_last;

    logic                     out_free;
    logic                     in_acc;
    logic                     is_full;
    logic                     is_empty;
    logic [CNT_W-1:0]         back_idx;
    t_cell_cmd                cell_cmd [DEPTH];
    logic signed [DATA_W-1:0] cell_q   [DEPTH];

    assign out_free    = !r_out_valid || o_out.ready;
    assign i_in.ready  = (r_state == ST_IDLE) && out_free;
    assign in_acc      = i_in.valid && i_in.ready;
    assign is_full     = (r_count == CNT_W'(DEPTH));
    assign is_empty    = (r_count == '0);
    assign back_idx    = r_count - 1'b1;

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_left        = r_left;
        n_out_valid   = r_out_valid && !o_out.ready;
        n_out_data    = r_out_data;
        n_out_status  = r_out_status;
        n_out_entries = r_out_entries;
        n_out_last    = r_out_last;
        for (int i = 0; i < DEPTH; i++) begin
            cell_cmd[i] = CELL_HOLD;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_out_valid  = 1'b1;
                    n_out_data   = '0;
                    n_out_status = STAT_DONE;
                    n_out_last   = 1'b1;
                    unique case (i_in.mode)
                        MODE_PUSH_FRONT: begin
                            if (is_full) begin
                                n_out_status = STAT_FULL;
                            end else begin
                                cell_cmd[0] = CELL_LOAD;
                                for (int i = 1; i < DEPTH; i++) begin
                                    cell_cmd[i] = CELL_FROM_PREV;
                                end
                                n_count = r_count + 1'b1;
                            end
                        end
                        MODE_PUSH_BACK: begin
                            if (is_full) begin
                                n_out_status = STAT_FULL;
                            end else begin
                                for (int i = 0; i < DEPTH; i++) begin
                                    if (CNT_W'(i) == r_count) begin
                                        cell_cmd[i] = CELL_LOAD;
                                    end
                                end
                                n_count = r_count + 1'b1;
                            end
                        end
                        MODE_POP_FRONT: begin
                            if (is_empty) begin
                                n_out_status = STAT_EMPTY;
                            end else begin
                                for (int i = 0; i < DEPTH - 1; i++) begin
                                    cell_cmd[i] = CELL_FROM_NEXT;
                                end
                                n_count = r_count - 1'b1;
                            end
                        end
                        MODE_POP_BACK: begin
                            if (is_empty) begin
                                n_out_status = STAT_EMPTY;
                            end else begin
                                n_count = r_count - 1'b1;
                            end
                        end
                        MODE_DUMP: begin
                            if (is_empty) begin
                                n_out_status = STAT_EMPTY;
                            end else begin
                                n_out_valid = 1'b0;
                                n_left      = r_count;
                                n_state     = ST_DUMP;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_out_entries = n_count;
                end
            end
            ST_DUMP: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_data    = cell_q[0];
                    n_out_status  = STAT_DONE;
                    n_out_entries = r_count;
                    n_out_last    = (r_left == CNT_W'(1));
                    for (int i = 0; i < DEPTH; i++) begin
                        if (CNT_W'(i) == back_idx) begin
                            cell_cmd[i] = CELL_FROM_HEAD;
                        end else if (CNT_W'(i) < back_idx) begin
                            cell_cmd[i] = CELL_FROM_NEXT;
                        end
                    end
                    n_left = r_left - 1'b1;
                    if (r_left == CNT_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data    <= n_out_data;
        r_out_status  <= n_out_status;
        r_out_entries <= n_out_entries;
        r_out_last    <= n_out_last;
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [DATA_W-1:0] prev_q;
        logic signed [DATA_W-1:0] next_q;
        if (g == 0) begin : g_first
            assign prev_q = '0;
        end else begin : g_mid
            assign prev_q = cell_q[g-1];
        end
        if (g == DEPTH - 1) begin : g_end
            assign next_q = cell_q[g];
        end else begin : g_inner
            assign next_q = cell_q[g+1];
        end
        deq_cell u_cell (
            .i_clk  (i_clk),
            .i_cmd  (cell_cmd[g]),
            .i_prev (prev_q),
            .i_next (next_q),
            .i_head (cell_q[0]),
            .i_load (i_in.value),
            .o_q    (cell_q[g])
        );
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.data    = r_out_data;
    assign o_out.status  = r_out_status;
    assign o_out.entries = r_out_entries;
    assign o_out.last    = r_out_last;

endmodule

>>> rtl/deq_checker.sv
module deq_checker
    import deq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_ready,
    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  logic signed [DATA_W-1:0] i_out_data,
    input  logic [STAT_W-1:0]        i_out_status,
    input  logic [CNT_W-1:0]         i_out_entries,
    input  logic                     i_out_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_data) && $stable(i_out_status)
            && $stable(i_out_entries) && $stable(i_out_last))
        else $error("output word changed while stalled");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status == STAT_FULL |-> i_out_entries == CNT_W'(DEPTH))
        else $error("full status with room left");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status == STAT_EMPTY |-> i_out_entries == '0)
        else $error("empty status with words stored");

    a_dump_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> !i_in_ready)
        else $error("input taken during dump");

endmodule

bind double_ended_queue deq_checker u_deq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_data    (o_out.data),
    .i_out_status  (o_out.status),
    .i_out_entries (o_out.entries),
    .i_out_last    (o_out.last)
);

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import deq_pkg::*;

    typedef struct {
        logic [MODE_W-1:0]        mode;
        logic signed [DATA_W-1:0] value;
    } in_word_t;

    typedef struct {
        logic signed [DATA_W-1:0] data;
        logic [STAT_W-1:0]        status;
        logic [CNT_W-1:0]         entries;
        logic                     last;
    } out_word_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    deq_in_if  in_ch ();
    deq_out_if out_ch ();

    double_ended_queue DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #5 i_clk = ~i_clk;

    in_word_t  stim_words[$];
    out_word_t expected_words[$];
    in_word_t  cur_word;

    logic signed [DATA_W-1:0] shadow_cells [DEPTH];
    int unsigned shadow_head = 0;
    int unsigned shadow_fill = 0;

    int unsigned words_queued = 0;
    int unsigned words_taken = 0;
    int unsigned mismatches = 0;
    int unsigned gap_in = 0;
    int unsigned stall_out = 0;
    bit burst_in = 1'b0;
    bit burst_out = 1'b0;

    initial begin
        in_ch.valid  = 1'b0;
        in_ch.mode   = '0;
        in_ch.value  = '0;
        out_ch.ready = 1'b0;
    end

    task automatic queue_result(input logic signed [DATA_W-1:0] data,
                                input logic [STAT_W-1:0] status, input logic last);
        out_word_t w;
        w.data    = data;
        w.status  = status;
        w.entries = shadow_fill[CNT_W-1:0];
        w.last    = last;
        expected_words.push_back(w);
    endtask

    task automatic apply_word(input in_word_t w);
        int unsigned k;
        case (w.mode)
            MODE_PUSH_FRONT: begin
                if (shadow_fill >= DEPTH) begin
                    queue_result('0, STAT_FULL, 1'b1);
                end else begin
                    shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
                    shadow_cells[shadow_head] = w.value;
                    shadow_fill++;
                    queue_result('0, STAT_DONE, 1'b1);
                end
            end
            MODE_PUSH_BACK: begin
                if (shadow_fill >= DEPTH) begin
                    queue_result('0, STAT_FULL, 1'b1);
                end else begin
                    shadow_cells[(shadow_head + shadow_fill) % DEPTH] = w.value;
                    shadow_fill++;
                    queue_result('0, STAT_DONE, 1'b1);
                end
            end
            MODE_POP_FRONT: begin
                if (shadow_fill == 0) begin
                    queue_result('0, STAT_EMPTY, 1'b1);
                end else begin
                    shadow_head = (shadow_head + 1) % DEPTH;
                    shadow_fill--;
                    queue_result('0, STAT_DONE, 1'b1);
                end
            end
            MODE_POP_BACK: begin
                if (shadow_fill == 0) begin
                    queue_result('0, STAT_EMPTY, 1'b1);
                end else begin
                    shadow_fill--;
                    queue_result('0, STAT_DONE, 1'b1);
                end
            end
            MODE_DUMP: begin
                if (shadow_fill == 0) begin
                    queue_result('0, STAT_EMPTY, 1'b1);
                end else begin
                    for (k = 0; k < shadow_fill; k++) begin
                        queue_result(shadow_cells[(shadow_head + k) % DEPTH], STAT_DONE,
                                     k + 1 == shadow_fill);
                    end
                end
            end
            default: begin
                queue_result('0, STAT_DONE, 1'b1);
            end
        endcase
    endtask

    task automatic add_word(input logic [MODE_W-1:0] mode,
                            input logic signed [DATA_W-1:0] value);
        in_word_t w;
        w.mode  = mode;
        w.value = value;
        stim_words.push_back(w);
        words_queued++;
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        logic signed [DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = 32'sh7fff_ffff;
            1: v = 32'sh8000_0000;
            2: v = '0;
            3: v = -32'sd1;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.mode  <= '0;
            in_ch.value <= '0;
            gap_in      <= 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                apply_word(cur_word);
                words_taken++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (gap_in > 0) begin
                    in_ch.valid <= 1'b0;
                    gap_in      <= gap_in - 1;
                end else if (stim_words.size() > 0) begin
                    cur_word = stim_words.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.mode  <= cur_word.mode;
                    in_ch.value <= cur_word.value;
                    if ($urandom_range(0, 15) == 0) burst_in = !burst_in;
                    gap_in <= burst_in ? 0 : $urandom_range(0, 6);
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watch
        int unsigned s;
        out_word_t want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_out    <= 0;
        end else begin
            s = stall_out;
            if (out_ch.valid && out_ch.ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word data=%0d status=%0d entries=%0d last=%0d",
                             $time, out_ch.data, out_ch.status, out_ch.entries, out_ch.last);
                    mismatches++;
                end else begin
                    want = expected_words.pop_front();
                    if (want.data !== out_ch.data || want.status !== out_ch.status ||
                        want.entries !== out_ch.entries || want.last !== out_ch.last) begin
                        $display("%0t: mismatch expected data=%0d status=%0d entries=%0d last=%0d",
                                 $time, want.data, want.status, want.entries, want.last);
                        $display("%0t:          actual   data=%0d status=%0d entries=%0d last=%0d",
                                 $time, out_ch.data, out_ch.status, out_ch.entries,
                                 out_ch.last);
                        mismatches++;
                    end
                end
                if ($urandom_range(0, 15) == 0) burst_out = !burst_out;
                s = burst_out ? 0 : $urandom_range(0, 6);
            end
            if (s > 0) begin
                out_ch.ready <= 1'b0;
                stall_out    <= s - 1;
            end else begin
                out_ch.ready <= 1'b1;
                stall_out    <= 0;
            end
        end
    end

    initial begin
        int i;
        int bias;
        int push_pct;
        int r;
        logic [MODE_W-1:0] m;

        add_word(MODE_DUMP, $urandom);
        add_word(MODE_POP_FRONT, $urandom);
        add_word(MODE_POP_BACK, $urandom);
        add_word(3'd5, $urandom);
        add_word(3'd6, $urandom);
        add_word(3'd7, $urandom);
        add_word(MODE_PUSH_FRONT, 32'sh7fff_ffff);
        add_word(MODE_PUSH_BACK, 32'sh8000_0000);
        for (i = 0; i < DEPTH - 2; i++) begin
            add_word(i[0] ? MODE_PUSH_FRONT : MODE_PUSH_BACK, $urandom);
        end
        add_word(MODE_PUSH_FRONT, -32'sd1);
        add_word(MODE_PUSH_BACK, '0);
        add_word(MODE_DUMP, $urandom);
        add_word(MODE_POP_FRONT, $urandom);
        add_word(MODE_POP_BACK, $urandom);
        add_word(MODE_DUMP, $urandom);

        bias = 0;
        for (i = 0; i < 400; i++) begin
            if (i % 40 == 0) bias = $urandom_range(0, 2);
            push_pct = (bias == 0) ? 75 : (bias == 1) ? 25 : 50;
            r = $urandom_range(0, 99);
            if (r < 10) begin
                m = MODE_DUMP;
            end else if (r < 13) begin
                m = MODE_W'($urandom_range(5, 7));
            end else if ($urandom_range(0, 99) < push_pct) begin
                m = $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
            end else begin
                m = $urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_BACK;
            end
            add_word(m, pick_value());
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (words_taken < words_queued || expected_words.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("PASS double_ended_queue");
        end else begin
            $display("FAIL double_ended_queue");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAIL double_ended_queue");
        $finish;
    end

endmodule

>>> filelist.f
rtl/deq_pkg.sv
rtl/deq_if.sv
rtl/deq_cell.sv
rtl/double_ended_queue.sv
rtl/deq_checker.sv
bench/testbench.sv
